[src/ialloc_pkg.sv]
// Package for the slot index allocator: pool sizing, field widths,
// operation and status codes, and the result record passed to the top level.
// No dependencies.
package ialloc_pkg;

    // Pool of slot indices handed out by the allocator.
    localparam int POOL_SIZE = 512;

    // Widths of the item fields, fixed by the channel definition.
    localparam int SLOT_W   = 9;
    localparam int STATUS_W = 2;

    // Widths of the queue pointers, the fill count and the bump counter.
    localparam int ADDR_W = (POOL_SIZE > 1) ? $clog2(POOL_SIZE) : 1;
    localparam int CNT_W  = $clog2(POOL_SIZE + 1);

    // Operation codes carried by the input item.
    localparam logic OP_ALLOCATE = 1'b0;
    localparam logic OP_FREE     = 1'b1;

    // Status codes carried by the result item.
    localparam logic [STATUS_W-1:0] ST_OK         = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EXHAUSTED  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_QUEUE_FULL = 2'd2;

    // One finished result item.
    typedef struct packed {
        logic [SLOT_W-1:0]   granted_index;
        logic [STATUS_W-1:0] status;
        logic                can_allocate;
    } res_t;

endpackage

[src/ialloc_ram.sv]
// Simple dual-port synchronous RAM holding the free queue entries.
// One write port and one read port with registered read data. No dependencies.
module ialloc_ram #(
    parameter int DATA_W = 9,
    parameter int DEPTH  = 512,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [DATA_W-1:0] wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    // Write port.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read port with registered read data.
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[src/ialloc_ctrl.sv]
// Allocator control: queue pointers, fill count, bump counter and the
// sequencer that pops and pushes the free queue RAM. Depends on ialloc_pkg
// and ialloc_ram.
module ialloc_ctrl (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic                     s_operation,
    input  logic [ialloc_pkg::SLOT_W-1:0] s_slot_index,
    output logic                     res_valid,
    input  logic                     res_ready,
    output ialloc_pkg::res_t         res
);
    import ialloc_pkg::*;

    // Sequencer states.
    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_READ = 2'd1;
    localparam logic [1:0] S_HOLD = 2'd2;

    logic [1:0]        state_reg, state_next;
    logic [ADDR_W-1:0] head_reg, head_next;
    logic [ADDR_W-1:0] tail_reg, tail_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [CNT_W-1:0]  fresh_reg, fresh_next;
    res_t              res_reg, res_next;

    logic              accept;
    logic              in_range;
    logic              ram_wr_en;
    logic              ram_rd_en;
    logic [SLOT_W-1:0] ram_rd_data;

    // Free queue storage.
    ialloc_ram #(
        .DATA_W (SLOT_W),
        .DEPTH  (POOL_SIZE),
        .ADDR_W (ADDR_W)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (tail_reg),
        .wr_data (s_slot_index),
        .rd_en   (ram_rd_en),
        .rd_addr (head_reg),
        .rd_data (ram_rd_data)
    );

    assign s_ready  = (state_reg == S_IDLE);
    assign accept   = s_valid && s_ready;
    assign in_range = (32'(s_slot_index) < 32'(POOL_SIZE));

    // Next-state logic: an item is decided in the accept cycle; a reuse of a
    // queued index waits in S_READ for the RAM read data.
    always_comb begin
        state_next = state_reg;
        head_next  = head_reg;
        tail_next  = tail_reg;
        count_next = count_reg;
        fresh_next = fresh_reg;
        res_next   = res_reg;
        ram_wr_en  = 1'b0;
        ram_rd_en  = 1'b0;

        unique case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    res_next.granted_index = '0;
                    res_next.status        = ST_OK;
                    state_next             = S_HOLD;
                    if (s_operation == OP_ALLOCATE) begin
                        if (count_reg != '0) begin
                            // Reuse the oldest freed index.
                            ram_rd_en  = 1'b1;
                            head_next  = (32'(head_reg) == POOL_SIZE - 1) ?
                                         '0 : head_reg + 1'b1;
                            count_next = count_reg - 1'b1;
                            state_next = S_READ;
                        end else if (32'(fresh_reg) < 32'(POOL_SIZE)) begin
                            // Hand out a never-used index.
                            res_next.granted_index = SLOT_W'(fresh_reg);
                            fresh_next             = fresh_reg + 1'b1;
                        end else begin
                            res_next.status = ST_EXHAUSTED;
                        end
                    end else if (in_range) begin
                        if (32'(count_reg) >= 32'(POOL_SIZE)) begin
                            res_next.status = ST_QUEUE_FULL;
                        end else begin
                            // Push the returned index at the tail.
                            ram_wr_en  = 1'b1;
                            tail_next  = (32'(tail_reg) == POOL_SIZE - 1) ?
                                         '0 : tail_reg + 1'b1;
                            count_next = count_reg + 1'b1;
                        end
                    end
                    res_next.can_allocate = (32'(fresh_next) < 32'(POOL_SIZE)) ||
                                            (count_next != '0);
                end
            end
            S_READ: begin
                res_next.granted_index = ram_rd_data;
                state_next             = S_HOLD;
            end
            S_HOLD: begin
                if (res_ready) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
            fresh_reg <= '0;
        end else begin
            state_reg <= state_next;
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
            fresh_reg <= fresh_next;
        end
    end

    // Result payload needs no reset.
    always_ff @(posedge aclk) begin
        res_reg <= res_next;
    end

    assign res_valid = (state_reg == S_HOLD);
    assign res       = res_reg;

endmodule

[src/index_allocator_fifo_free_list.sv]
// Top level of the slot index allocator: control with the free queue RAM and
// the output register of the result channel. Depends on ialloc_pkg and
// ialloc_ctrl.
//
// Usage: each input item is either an allocate (s_operation = 0) or a free of
// s_slot_index (s_operation = 1); every item yields exactly one result item
// with the granted index, a status code and a flag saying whether a further
// allocate would succeed.
// Both channels use valid/ready handshakes.
// Path: a result reaches m_valid through the control's result register and
// the output register; when a freed index is reused, the free queue RAM read
// and the S_READ state come first.
// Flow: the sequencer handles one item at a time and keeps s_ready low until
// it is idle again; an allocate that pops the free queue also waits for the
// RAM read.
// Reset: aresetn (synchronous, active low) empties the free queue and rewinds
// the bump counter; the queue RAM is not cleared and needs no clearing pass.
// Stall: the output register holds a result while m_ready is low, and the
// block still takes and works one further item meanwhile; it then holds that
// result and keeps s_ready low until the output register is free.
module index_allocator_fifo_free_list (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic                                s_operation,
    input  logic [ialloc_pkg::SLOT_W-1:0]       s_slot_index,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [ialloc_pkg::SLOT_W-1:0]       m_granted_index,
    output logic [ialloc_pkg::STATUS_W-1:0]     m_status,
    output logic                                m_can_allocate
);
    import ialloc_pkg::*;

    logic res_valid;
    logic res_ready;
    res_t res;
    logic m_valid_reg, m_valid_next;
    res_t out_reg;

    ialloc_ctrl u_ctrl (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_operation  (s_operation),
        .s_slot_index (s_slot_index),
        .res_valid    (res_valid),
        .res_ready    (res_ready),
        .res          (res)
    );

    // The output register takes a new item when empty or being drained.
    assign res_ready = !m_valid_reg || m_ready;

    always_comb begin
        m_valid_next = m_valid_reg;
        if (res_ready) begin
            m_valid_next = res_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    // Result payload.
    always_ff @(posedge aclk) begin
        if (res_ready && res_valid) begin
            out_reg <= res;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_granted_index = out_reg.granted_index;
    assign m_status        = out_reg.status;
    assign m_can_allocate  = out_reg.can_allocate;

endmodule
